@@ hw/rtl/itrd_pkg.sv @@
// Shared types, constants and the digit character function for the radix digit converter.
`timescale 1ns / 1ps

package itrd_pkg;

    localparam int VALUE_W           = 32;
    localparam int RADIX_W           = 5;
    localparam int CHAR_W            = 8;
    localparam int DIGITS_MAX        = 32;
    localparam int IDX_W             = 5;
    localparam int CNT_W             = 6;
    localparam int CHUNK_BITS        = 8;
    localparam int CHUNK_CNT_W       = 2;
    localparam int DIGIT_ARG_W       = 6;
    localparam int MAX_RADIX_DEFAULT = 16;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER = 8'h61;
    localparam logic [DIGIT_ARG_W-1:0] DIGIT_TOP = 6'd35;
    localparam logic [DIGIT_ARG_W-1:0] DIGIT_TEN = 6'd10;

    localparam logic OP_UNSIGNED = 1'b0;
    localparam logic OP_SIGNED   = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic emit_sign;
        logic emit_digit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic neg;
        logic cnt_one;
        logic out_free;
    } t_dp_status;

    // ASCII code of one digit; digits of ten and up become letters.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_ARG_W-1:0] d,
                                                     input logic upper);
        logic [DIGIT_ARG_W-1:0] dc;
        logic [CHAR_W-1:0]      c;
        dc = (d > DIGIT_TOP) ? DIGIT_TOP : d;
        if (dc < DIGIT_TEN) begin
            c = CHAR_ZERO + CHAR_W'(dc);
        end else if (upper) begin
            c = CHAR_UPPER + CHAR_W'(dc - DIGIT_TEN);
        end else begin
            c = CHAR_LOWER + CHAR_W'(dc - DIGIT_TEN);
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/integer_to_radix_digits.sv @@
// Top level of the radix digit converter: controller, datapath and configuration port.
`timescale 1ns / 1ps

// Converts one 32-bit number per request into its ASCII text in a base from 2 to
// MAX_RADIX, one character per output request, most significant digit first, with no
// leading zeros and a single '0' for zero. With i_opcode set, a negative value first
// gives '-' and then its magnitude; the most negative value prints 2^31. Bases below 2
// are taken as 2 and bases above MAX_RADIX as MAX_RADIX. The final character of each
// number has o_last_char set. The uppercase_letters register, written through the
// configuration channel, selects 'A'-'Z' over 'a'-'z' for digits of ten and up.
// The block works on one number at a time. It accepts a number, divides it with one full
// pass of the divider per digit, then emits the digits (after '-' for a negative value),
// holding while the output is stalled. The divider handles 8 bits of the 32-bit value
// per cycle. The final character waits in the output register while the next number
// is already accepted.

module integer_to_radix_digits #(
    parameter int MAX_RADIX = itrd_pkg::MAX_RADIX_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input requests.
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [itrd_pkg::VALUE_W-1:0] i_value,
    input  logic [itrd_pkg::RADIX_W-1:0] i_radix,
    input  logic                         i_opcode,
    // Output requests.
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [itrd_pkg::CHAR_W-1:0]  o_character,
    output logic                         o_last_char,
    // Configuration write channel.
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_data
);

    itrd_pkg::t_dp_cmd    cmd;
    itrd_pkg::t_dp_status status;
    logic                 cfg_write;

    // Always writable; the user makes writes only while the block is idle; not enforced.
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    itrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    itrd_dp #(
        .MAX_RADIX (MAX_RADIX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_value     (i_value),
        .i_radix     (i_radix),
        .i_opcode    (i_opcode),
        .i_cfg_write (cfg_write),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_character (o_character),
        .o_last_char (o_last_char)
    );

`ifndef SYNTHESIS
    // An accepted request keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block not busy after accepting a request");

    // Once the final character is taken, nothing follows until the next division is done.
    a_quiet_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_char) |=> !o_out_valid)
        else $error("character emitted right after the final one");

    // While a character that is not the final one is taken, the block is still working
    // on the number.
    a_busy_mid_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_char) |-> o_in_stall)
        else $error("block went idle in the middle of a number");

    // The minus sign always has digits after it.
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_character == itrd_pkg::CHAR_MINUS)) |-> !o_last_char)
        else $error("minus sign flagged as final character");
`endif

endmodule

@@ hw/rtl/itrd_dp.sv @@
// Datapath of the radix digit converter: divider, digit stack and output register.
`timescale 1ns / 1ps

module itrd_dp #(
    parameter int MAX_RADIX = itrd_pkg::MAX_RADIX_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  itrd_pkg::t_dp_cmd                   i_cmd,
    output itrd_pkg::t_dp_status                o_status,
    input  logic [itrd_pkg::VALUE_W-1:0]        i_value,
    input  logic [itrd_pkg::RADIX_W-1:0]        i_radix,
    input  logic                                i_opcode,
    input  logic                                i_cfg_write,
    input  logic                                i_cfg_data,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [itrd_pkg::CHAR_W-1:0]         o_character,
    output logic                                o_last_char
);

    localparam int RW = $clog2(MAX_RADIX);
    localparam int BW = $clog2(MAX_RADIX + 1);
    localparam int VW = itrd_pkg::VALUE_W;
    localparam int CB = itrd_pkg::CHUNK_BITS;

    logic [VW-1:0]                       r_quot, n_quot;
    logic [RW-1:0]                       r_rem, n_rem;
    logic [BW-1:0]                       r_base;
    logic                                r_neg;
    logic [itrd_pkg::CHUNK_CNT_W-1:0]    r_chunk;
    logic [itrd_pkg::CNT_W-1:0]          r_cnt;
    logic [RW-1:0]                       r_digits [itrd_pkg::DIGITS_MAX];
    logic                                r_upper;
    logic                                r_out_valid;
    logic [itrd_pkg::CHAR_W-1:0]         r_char;
    logic                                r_last;

    logic [VW-1:0]                       radix_ext;
    logic [VW-1:0]                       base_sel;
    logic                                in_neg;
    logic [VW-1:0]                       magnitude;
    logic [CB-1:0]                       qbits;
    logic                                chunk_last;
    logic [itrd_pkg::CNT_W-1:0]          cnt_m1;
    logic [RW-1:0]                       top_digit;

    // Clamp the requested base into 2..MAX_RADIX.
    always_comb begin
        radix_ext = VW'(i_radix);
        if (radix_ext < VW'(2)) begin
            base_sel = VW'(2);
        end else if (radix_ext > VW'(MAX_RADIX)) begin
            base_sel = VW'(MAX_RADIX);
        end else begin
            base_sel = radix_ext;
        end
    end

    assign in_neg    = (i_opcode == itrd_pkg::OP_SIGNED) && i_value[VW-1];
    assign magnitude = in_neg ? (~i_value + VW'(1)) : i_value;

    // Eight restoring division steps over the top byte of the quotient register.
    always_comb begin
        logic [RW:0] t;
        logic [RW-1:0] rem;
        rem   = r_rem;
        qbits = '0;
        for (int i = 0; i < CB; i++) begin
            t = {rem, r_quot[VW-1-i]};
            if (t >= (RW+1)'(r_base)) begin
                t = t - (RW+1)'(r_base);
                qbits[CB-1-i] = 1'b1;
            end
            rem = t[RW-1:0];
        end
        n_rem  = rem;
        n_quot = {r_quot[VW-CB-1:0], qbits};
    end

    assign chunk_last = (r_chunk == {itrd_pkg::CHUNK_CNT_W{1'b1}});
    assign cnt_m1     = r_cnt - itrd_pkg::CNT_W'(1);
    assign top_digit  = r_digits[cnt_m1[itrd_pkg::IDX_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk     <= '0;
            r_cnt       <= '0;
            r_upper     <= 1'b0;
            r_out_valid <= 1'b0;
            r_rem       <= '0;
        end else begin
            if (i_cfg_write) begin
                r_upper <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_chunk <= '0;
                r_cnt   <= '0;
                r_rem   <= '0;
            end else if (i_cmd.div_step) begin
                r_chunk <= r_chunk + itrd_pkg::CHUNK_CNT_W'(1);
                if (chunk_last) begin
                    r_rem <= '0;
                    r_cnt <= r_cnt + itrd_pkg::CNT_W'(1);
                end else begin
                    r_rem <= n_rem;
                end
            end else if (i_cmd.emit_digit) begin
                r_cnt <= cnt_m1;
            end
            if (i_cmd.emit_sign || i_cmd.emit_digit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quot <= magnitude;
            r_base <= base_sel[BW-1:0];
            r_neg  <= in_neg;
        end else if (i_cmd.div_step) begin
            r_quot <= n_quot;
            if (chunk_last) begin
                r_digits[r_cnt[itrd_pkg::IDX_W-1:0]] <= n_rem;
            end
        end
        if (i_cmd.emit_sign) begin
            r_char <= itrd_pkg::CHAR_MINUS;
            r_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_char <= itrd_pkg::digit_char(itrd_pkg::DIGIT_ARG_W'(top_digit), r_upper);
            r_last <= (r_cnt == itrd_pkg::CNT_W'(1));
        end
    end

    assign o_status.div_done = chunk_last && (n_quot == '0);
    assign o_status.neg      = r_neg;
    assign o_status.cnt_one  = (r_cnt == itrd_pkg::CNT_W'(1));
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_character = r_char;
    assign o_last_char = r_last;

endmodule

@@ hw/rtl/itrd_ctrl.sv @@
// Controller state machine of the radix digit converter.
`timescale 1ns / 1ps

module itrd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  itrd_pkg::t_dp_status i_status,
    output itrd_pkg::t_dp_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = i_status.neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (i_status.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_status.cnt_one) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

@@ verif/integer_to_radix_digits_test.sv @@
// Self-checking testbench for the radix digit converter with a built-in text predictor.
`timescale 1ns / 1ps

module integer_to_radix_digits_test;

    localparam int MAX_BASE       = itrd_pkg::MAX_RADIX_DEFAULT;
    localparam int RANDOM_NUMBERS = 112;   // per idling phase, four phases
    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [itrd_pkg::VALUE_W-1:0] value;
        logic [itrd_pkg::RADIX_W-1:0] radix;
        logic                         opcode;
    } t_number_req;

    typedef struct {
        logic [itrd_pkg::CHAR_W-1:0] code;
        logic                        last;
    } t_text_char;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_in_valid  = 1'b0;
    logic                         o_in_stall;
    logic [itrd_pkg::VALUE_W-1:0] i_value     = '0;
    logic [itrd_pkg::RADIX_W-1:0] i_radix     = '0;
    logic                         i_opcode    = itrd_pkg::OP_UNSIGNED;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic [itrd_pkg::CHAR_W-1:0]  o_character;
    logic                         o_last_char;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic                         i_cfg_data  = 1'b0;

    t_number_req pending_numbers[$];
    t_text_char  expected_text[$];
    logic        upper_letters = 1'b0;
    int          sender_idle_pct    = 0;
    int          receiver_stall_pct = 0;
    int          error_count        = 0;
    int          quiet_cycles       = 0;

    integer_to_radix_digits #(
        .MAX_RADIX (MAX_BASE)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .i_radix     (i_radix),
        .i_opcode    (i_opcode),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_character (o_character),
        .o_last_char (o_last_char),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Queues the characters that one accepted number should produce.
    function automatic void predict_text(input logic [itrd_pkg::VALUE_W-1:0] number,
                                         input logic [itrd_pkg::RADIX_W-1:0] radix_in,
                                         input logic op);
        logic [itrd_pkg::VALUE_W-1:0] base;
        logic [itrd_pkg::VALUE_W-1:0] magnitude;
        logic [itrd_pkg::VALUE_W-1:0] place;
        logic [itrd_pkg::VALUE_W-1:0] probe;
        logic [itrd_pkg::VALUE_W-1:0] digit;
        t_text_char                   ch;
        if (radix_in < 2) begin
            base = 2;
        end else if (radix_in > MAX_BASE) begin
            base = MAX_BASE;
        end else begin
            base = itrd_pkg::VALUE_W'(radix_in);
        end
        magnitude = number;
        if (op == itrd_pkg::OP_SIGNED && number[itrd_pkg::VALUE_W-1]) begin
            ch.code = itrd_pkg::CHAR_MINUS;
            ch.last = 1'b0;
            expected_text.push_back(ch);
            // The most negative value wraps onto itself, which is 2^31 unsigned.
            magnitude = -number;
        end
        place = 1;
        probe = magnitude;
        while (probe >= base) begin
            probe = probe / base;
            place = place * base;
        end
        while (place != 0) begin
            digit = magnitude / place;
            if (digit > 35) begin
                digit = 35;
            end
            if (digit < 10) begin
                ch.code = itrd_pkg::CHAR_ZERO + itrd_pkg::CHAR_W'(digit);
            end else if (upper_letters) begin
                ch.code = itrd_pkg::CHAR_UPPER + itrd_pkg::CHAR_W'(digit - 10);
            end else begin
                ch.code = itrd_pkg::CHAR_LOWER + itrd_pkg::CHAR_W'(digit - 10);
            end
            magnitude = magnitude % place;
            place = place / base;
            ch.last = (place == 0);
            expected_text.push_back(ch);
        end
    endfunction

    task automatic add_number(input logic [itrd_pkg::VALUE_W-1:0] value,
                              input logic [itrd_pkg::RADIX_W-1:0] radix,
                              input logic op);
        t_number_req req;
        req.value  = value;
        req.radix  = radix;
        req.opcode = op;
        pending_numbers.push_back(req);
    endtask

    task automatic write_upper(input logic setting);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= setting;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid   <= 1'b0;
        upper_letters = setting;
    endtask

    // Holds the sender back until every queued number has been fully printed.
    task automatic wait_drained();
        while (pending_numbers.size() != 0 || i_in_valid || expected_text.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Number driver: the prediction is made at the edge where a request is taken.
    always @(posedge i_clk) begin : drive_numbers
        t_number_req req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_text(i_value, i_radix, i_opcode);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_numbers.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    req = pending_numbers.pop_front();
                    i_in_valid <= 1'b1;
                    i_value    <= req.value;
                    i_radix    <= req.radix;
                    i_opcode   <= req.opcode;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    always @(posedge i_clk) begin : check_text
        t_text_char want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_text.size() == 0) begin
                $error("unexpected character %h (last_char %b)", o_character, o_last_char);
                error_count++;
            end else begin
                want = expected_text.pop_front();
                if (o_character !== want.code) begin
                    $error("character: expected %h, actual %h", want.code, o_character);
                    error_count++;
                end
                if (o_last_char !== want.last) begin
                    $error("last_char: expected %b, actual %b", want.last, o_last_char);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which no channel moves a request.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : run_phases
        logic [itrd_pkg::VALUE_W-1:0] value;
        logic [itrd_pkg::RADIX_W-1:0] radix;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed numbers, letters in upper case.
        write_upper(1'b1);
        add_number(32'h0000_0000, 5'd10, itrd_pkg::OP_UNSIGNED);
        add_number(32'h0000_0000, 5'd2,  itrd_pkg::OP_SIGNED);
        add_number(32'hFFFF_FFFF, 5'd2,  itrd_pkg::OP_UNSIGNED);
        add_number(32'hFFFF_FFFF, 5'd16, itrd_pkg::OP_UNSIGNED);
        add_number(32'hFFFF_FFFF, 5'd10, itrd_pkg::OP_SIGNED);
        add_number(32'h8000_0000, 5'd2,  itrd_pkg::OP_SIGNED);
        add_number(32'h8000_0000, 5'd10, itrd_pkg::OP_SIGNED);
        add_number(32'h8000_0000, 5'd16, itrd_pkg::OP_SIGNED);
        add_number(32'h8000_0000, 5'd2,  itrd_pkg::OP_UNSIGNED);
        add_number(32'h7FFF_FFFF, 5'd10, itrd_pkg::OP_SIGNED);
        add_number(32'h7FFF_FFFF, 5'd3,  itrd_pkg::OP_UNSIGNED);
        add_number(32'h0000_00FF, 5'd16, itrd_pkg::OP_UNSIGNED);
        add_number(32'h0000_000A, 5'd11, itrd_pkg::OP_UNSIGNED);
        add_number(32'h0000_3039, 5'd13, itrd_pkg::OP_SIGNED);
        add_number(32'h0000_3039, 5'd7,  itrd_pkg::OP_UNSIGNED);
        add_number(32'h0000_0064, 5'd0,  itrd_pkg::OP_UNSIGNED);
        add_number(32'h0000_0064, 5'd1,  itrd_pkg::OP_SIGNED);
        add_number(32'hDEAD_BEEF, 5'd17, itrd_pkg::OP_UNSIGNED);
        add_number(32'hDEAD_BEEF, 5'd31, itrd_pkg::OP_SIGNED);
        add_number(32'h0000_0010, 5'd16, itrd_pkg::OP_UNSIGNED);
        add_number(32'hFFFF_FFF1, 5'd16, itrd_pkg::OP_SIGNED);
        wait_drained();

        // Random numbers under each idling pattern, alternating letter case.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct <= 0;  receiver_stall_pct <= 0;  end
                1: begin sender_idle_pct <= 46; receiver_stall_pct <= 0;  end
                2: begin sender_idle_pct <= 0;  receiver_stall_pct <= 46; end
                default: begin sender_idle_pct <= 12; receiver_stall_pct <= 12; end
            endcase
            write_upper(phase[0]);
            for (int n = 0; n < RANDOM_NUMBERS; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    radix = itrd_pkg::RADIX_W'($urandom_range(0, 31));
                end else begin
                    radix = itrd_pkg::RADIX_W'($urandom_range(2, MAX_BASE));
                end
                case ($urandom_range(0, 4))
                    0: value = $urandom;
                    1: value = $urandom_range(0, 100);
                    2: value = {1'b1, 31'($urandom)};
                    3: value = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
                    default: value = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
                                                          : 32'h8000_0000 + $urandom_range(0, 3);
                endcase
                add_number(value, radix, 1'($urandom_range(0, 1)));
            end
            wait_drained();
        end

        if (expected_text.size() != 0) begin
            $error("%0d characters never arrived", expected_text.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/itrd_pkg.sv
hw/rtl/itrd_dp.sv
hw/rtl/itrd_ctrl.sv
hw/rtl/integer_to_radix_digits.sv
verif/integer_to_radix_digits_test.sv
